// ===== src/ams_pkg.sv =====
// ----------------------------------------------------------------------------
// ams_pkg
// Shared types and constants for the accumulator machine step block:
// request and response payloads, opcodes, fault codes and sequencer states.
// ----------------------------------------------------------------------------
package ams_pkg;

    // word memory geometry (depth is a power of two, operands wrap by truncation)
    localparam int MEM_DEPTH = 256;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int WORD_W    = 32;
    localparam int PC_OUT_W  = 8;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [WORD_W-1:0] word_t;

    // request kinds
    localparam logic OP_LOAD_WORD = 1'b0;
    localparam logic OP_STEP      = 1'b1;

    // instruction opcodes, OPC_NONE marks any word that is not an instruction
    typedef logic [3:0] opc_t;
    localparam opc_t OPC_NONE   = 4'd0;
    localparam opc_t OPC_ADD    = 4'd1;
    localparam opc_t OPC_SUB    = 4'd2;
    localparam opc_t OPC_MUL    = 4'd3;
    localparam opc_t OPC_DIV    = 4'd4;
    localparam opc_t OPC_JMP    = 4'd5;
    localparam opc_t OPC_JMPN   = 4'd6;
    localparam opc_t OPC_JMPP   = 4'd7;
    localparam opc_t OPC_JMPZ   = 4'd8;
    localparam opc_t OPC_COPY   = 4'd9;
    localparam opc_t OPC_LOAD   = 4'd10;
    localparam opc_t OPC_STORE  = 4'd11;
    localparam opc_t OPC_INPUT  = 4'd12;
    localparam opc_t OPC_OUTPUT = 4'd13;
    localparam opc_t OPC_STOP   = 4'd14;

    // fault codes
    typedef logic [1:0] fault_t;
    localparam fault_t FAULT_NONE   = 2'd0;
    localparam fault_t FAULT_DIV0   = 2'd1;
    localparam fault_t FAULT_OPCODE = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPC,
        ST_OPND,
        ST_DATA,
        ST_COPY,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               op;
        logic [7:0]         address;
        logic signed [31:0] data;
        logic signed [31:0] in_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] acc_value;
        logic [7:0]         pc_value;
        logic               out_valid;
        logic signed [31:0] out_value;
        logic               halted;
        logic [1:0]         fault;
    } rsp_t;

endpackage

// ===== src/ams_div.sv =====
// ----------------------------------------------------------------------------
// ams_div
// Signed 32-bit divider, truncating toward zero. Restoring algorithm on
// magnitudes, one quotient bit per cycle. done pulses for one cycle when the
// quotient is ready; the quotient holds until the next start.
// ----------------------------------------------------------------------------
module ams_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ams_pkg::word_t dividend,
    input  ams_pkg::word_t divisor,
    output logic           done,
    output ams_pkg::word_t quotient
);
    import ams_pkg::*;

    localparam int DIV_STEPS = WORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            rem_reg, rem_next;
    word_t            quo_reg, quo_next;
    word_t            den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [WORD_W:0]  shifted;
    logic [WORD_W+1:0] diff;

    // operand setup on start, otherwise one restoring step while busy
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[WORD_W-1]};
        diff      = {1'b0, shifted} - {2'b00, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
            quo_next  = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
            den_next  = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
            neg_next  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W+1])
            begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (WORD_W'(0) - quo_reg) : quo_reg;

endmodule

// ===== src/accumulator_machine_step_top.sv =====
// ----------------------------------------------------------------------------
// accumulator_machine_step_top
// Accumulator machine with one word memory for code and data. A load request
// writes one word; a step request executes the instruction at the program
// counter and returns accumulator, pc, output value, halt state and fault.
// ----------------------------------------------------------------------------
// One request is worked at a time and every request returns one response.
// A step fetches opcode, operand and data word one after another (COPY: opcode,
// both operands, then the data word) through the single read port of the word
// memory, which has a registered read. DIV then waits in ST_DIV for the divider,
// which retires one quotient bit per cycle. A new request is taken as soon as
// the response is in the output register; a response that is still held there
// delays only the end of the next one. The word memory is not cleared at reset:
// reading a word never written returns whatever the memory holds.
module accumulator_machine_step_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ams_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ams_pkg::rsp_t rsp
);
    import ams_pkg::*;

    state_t  state_reg, state_next;
    word_t   acc_reg, acc_next;
    addr_t   pc_reg, pc_next;
    logic    halted_reg, halted_next;
    logic    rsp_valid_reg, rsp_valid_next;
    rsp_t    rsp_reg, rsp_next;
    opc_t    opc_reg, opc_next;
    addr_t   a1_reg, a1_next;
    addr_t   a2_reg, a2_next;
    word_t   in_value_reg, in_value_next;
    logic    ov_reg, ov_next;
    word_t   outv_reg, outv_next;
    fault_t  fault_reg, fault_next;

    word_t   mem [MEM_DEPTH];
    word_t   rdata_reg;
    addr_t   rd_addr;
    logic    mem_we;
    addr_t   mem_waddr;
    word_t   mem_wdata;

    word_t   product;
    logic    div_start;
    logic    div_done;
    word_t   div_quotient;
    logic    req_take;

    // instruction word to opcode, anything out of range is no instruction
    function automatic opc_t decode_opc(word_t w);
        opc_t res;
        res = OPC_NONE;
        if ((w[WORD_W-1:4] == '0) && (w[3:0] >= OPC_ADD) && (w[3:0] <= OPC_STOP))
        begin
            res = opc_t'(w[3:0]);
        end
        return res;
    endfunction

    ams_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (rdata_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign product   = acc_reg * rdata_reg;

    // sequencer: a load writes one word; a step fetches opcode, operand, data word, then executes
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        pc_next        = pc_reg;
        halted_next    = halted_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        opc_next       = opc_reg;
        a1_next        = a1_reg;
        a2_next        = a2_reg;
        in_value_next  = in_value_reg;
        ov_next        = ov_reg;
        outv_next      = outv_reg;
        fault_next     = fault_reg;
        rd_addr        = pc_reg;
        mem_we         = 1'b0;
        mem_waddr      = a1_reg;
        mem_wdata      = acc_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    ov_next       = 1'b0;
                    outv_next     = '0;
                    fault_next    = FAULT_NONE;
                    in_value_next = req.in_value;
                    if (req.op == OP_LOAD_WORD)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = ADDR_W'(req.address);
                        mem_wdata  = req.data;
                        state_next = ST_DONE;
                    end
                    else if (halted_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_addr    = pc_reg;
                        state_next = ST_OPC;
                    end
                end
            end

            ST_OPC:
            begin
                opc_next   = decode_opc(rdata_reg);
                rd_addr    = pc_reg + ADDR_W'(1);
                state_next = ST_OPND;
            end

            ST_OPND:
            begin
                a1_next    = ADDR_W'(rdata_reg);
                rd_addr    = (opc_reg == OPC_COPY) ? (pc_reg + ADDR_W'(2)) : ADDR_W'(rdata_reg);
                state_next = ST_DATA;
            end

            ST_DATA:
            begin
                state_next = ST_DONE;
                unique case (opc_reg)
                    OPC_ADD:
                    begin
                        acc_next = acc_reg + rdata_reg;
                        pc_next  = pc_reg + ADDR_W'(2);
                    end
                    OPC_SUB:
                    begin
                        acc_next = acc_reg - rdata_reg;
                        pc_next  = pc_reg + ADDR_W'(2);
                    end
                    OPC_MUL:
                    begin
                        acc_next = product;
                        pc_next  = pc_reg + ADDR_W'(2);
                    end
                    OPC_DIV:
                    begin
                        if (rdata_reg == '0)
                        begin
                            fault_next = FAULT_DIV0;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    OPC_JMP:
                    begin
                        pc_next = a1_reg;
                    end
                    OPC_JMPN:
                    begin
                        pc_next = acc_reg[WORD_W-1] ? a1_reg : (pc_reg + ADDR_W'(2));
                    end
                    OPC_JMPP:
                    begin
                        pc_next = (!acc_reg[WORD_W-1] && (acc_reg != '0)) ? a1_reg
                                                                          : (pc_reg + ADDR_W'(2));
                    end
                    OPC_JMPZ:
                    begin
                        pc_next = (acc_reg == '0) ? a1_reg : (pc_reg + ADDR_W'(2));
                    end
                    OPC_COPY:
                    begin
                        a2_next    = ADDR_W'(rdata_reg);
                        rd_addr    = a1_reg;
                        state_next = ST_COPY;
                    end
                    OPC_LOAD:
                    begin
                        acc_next = rdata_reg;
                        pc_next  = pc_reg + ADDR_W'(2);
                    end
                    OPC_STORE:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = a1_reg;
                        mem_wdata = acc_reg;
                        pc_next   = pc_reg + ADDR_W'(2);
                    end
                    OPC_INPUT:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = a1_reg;
                        mem_wdata = in_value_reg;
                        pc_next   = pc_reg + ADDR_W'(2);
                    end
                    OPC_OUTPUT:
                    begin
                        ov_next   = 1'b1;
                        outv_next = rdata_reg;
                        pc_next   = pc_reg + ADDR_W'(2);
                    end
                    OPC_STOP:
                    begin
                        halted_next = 1'b1;
                    end
                    default:
                    begin
                        fault_next = FAULT_OPCODE;
                    end
                endcase
            end

            ST_COPY:
            begin
                mem_we     = 1'b1;
                mem_waddr  = a2_reg;
                mem_wdata  = rdata_reg;
                pc_next    = pc_reg + ADDR_W'(3);
                state_next = ST_DONE;
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    acc_next   = div_quotient;
                    pc_next    = pc_reg + ADDR_W'(2);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.acc_value = acc_reg;
                    rsp_next.pc_value  = PC_OUT_W'(pc_reg);
                    rsp_next.out_valid = ov_reg;
                    rsp_next.out_value = outv_reg;
                    rsp_next.halted    = halted_reg;
                    rsp_next.fault     = fault_reg;
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            pc_reg        <= '0;
            halted_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            pc_reg        <= pc_next;
            halted_reg    <= halted_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg      <= rsp_next;
        opc_reg      <= opc_next;
        a1_reg       <= a1_next;
        a2_reg       <= a2_next;
        in_value_reg <= in_value_next;
        ov_reg       <= ov_next;
        outv_reg     <= outv_next;
        fault_reg    <= fault_next;
    end

    // word memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
